// File: hdl/lqs_pkg.sv
// Package for the linear queue with search unit.
// Holds the item structs, the opcode and status codes and the default depth.
// No dependencies.
package lqs_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned WordW        = 32;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_LIST    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ELEMENT   = 3'd5
  } status_e;

  typedef struct packed {
    opcode_e                  opcode;
    logic signed [WordW-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WordW-1:0]  data;
    logic                     last;
  } out_item_t;

endpackage

// File: hdl/lqs_cell.sv
// One storage cell of the rotating queue chain.
// Takes a word from its neighbor when the chain rotates, or a new word on write.
// Depends on lqs_pkg.
module lqs_cell (
  input  logic                            clk_i,
  input  logic                            shift_i,
  input  logic signed [lqs_pkg::WordW-1:0] next_i,
  input  logic                            wr_i,
  input  logic signed [lqs_pkg::WordW-1:0] wr_data_i,
  output logic signed [lqs_pkg::WordW-1:0] data_o
);
  import lqs_pkg::*;

  logic signed [WordW-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      word_q <= wr_data_i;
    end else if (shift_i) begin
      word_q <= next_i;
    end
  end

  assign data_o = word_q;

endmodule

// File: hdl/linear_queue_with_search_unit.sv
// Top level of the linear queue with search unit.
// Holds the control state machine, the output register and the row of lqs_cell.
// Depends on lqs_pkg and lqs_cell.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+--------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/ out_stall_i| out_item_o (out_item_t)
//
// Enqueue and dequeue are accepted in the idle state and carried out in the execute state.
// Search and list rotate the whole cell chain once past cell zero in the walk state;
// a search then gives its answer from the search result state.
// A stalled output pauses the rotation of a list and holds the execute step.
// Reset empties the queue; the cell contents are not cleared.
module linear_queue_with_search_unit #(
  parameter int unsigned DEPTH = lqs_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lqs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lqs_pkg::out_item_t out_item_o
);
  import lqs_pkg::*;

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned StepW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_SRES = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  opcode_e                 op_q, op_d;
  logic signed [WordW-1:0] key_q, key_d;
  logic [CntW-1:0]         wr_cnt_q, wr_cnt_d;
  logic [CntW-1:0]         occ_q, occ_d;
  logic [StepW-1:0]        step_q, step_d;
  logic                    found_q, found_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q, out_item_d;

  logic                    shift;
  logic                    wr_en;
  logic                    out_free;
  logic                    in_fire;
  logic                    in_range;
  logic signed [WordW-1:0] cell_data [DEPTH];

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_range    = (CntW'(step_q) < occ_q);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    lqs_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .next_i    (cell_data[(k + 1) % DEPTH]),
      .wr_i      (wr_en && (occ_q == CntW'(k))),
      .wr_data_i (key_q),
      .data_o    (cell_data[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    wr_cnt_d    = wr_cnt_q;
    occ_d       = occ_q;
    step_d      = step_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    shift       = 1'b0;
    wr_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = in_item_i.opcode;
          key_d   = in_item_i.value;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_item_d.data = '0;
          out_item_d.last = 1'b1;
          case (op_q)
            OP_ENQUEUE: begin
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
              if (wr_cnt_q == CntW'(DEPTH)) begin
                out_item_d.status = ST_FULL;
              end else begin
                wr_en             = 1'b1;
                wr_cnt_d          = wr_cnt_q + 1'b1;
                occ_d             = occ_q + 1'b1;
                out_item_d.status = ST_ENQUEUED;
              end
            end
            OP_DEQUEUE: begin
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
              if (occ_q == '0) begin
                out_item_d.status = ST_EMPTY;
              end else begin
                shift             = 1'b1;
                occ_d             = occ_q - 1'b1;
                out_item_d.status = ST_ELEMENT;
                out_item_d.data   = cell_data[0];
              end
            end
            default: begin
              if (occ_q == '0) begin
                out_valid_d       = 1'b1;
                out_item_d.status = ST_EMPTY;
                state_d           = S_IDLE;
              end else begin
                step_d  = '0;
                found_d = 1'b0;
                state_d = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if (op_q == OP_LIST && in_range) begin
          if (out_free) begin
            shift             = 1'b1;
            out_valid_d       = 1'b1;
            out_item_d.status = ST_ELEMENT;
            out_item_d.data   = cell_data[0];
            out_item_d.last   = ((CntW'(step_q) + CntW'(1)) == occ_q);
          end
        end else begin
          shift = 1'b1;
          if (in_range && (cell_data[0] == key_q)) begin
            found_d = 1'b1;
          end
        end
        if (shift) begin
          step_d = step_q + 1'b1;
          if (step_q == StepW'(DEPTH - 1)) begin
            state_d = (op_q == OP_LIST) ? S_IDLE : S_SRES;
          end
        end
      end
      S_SRES: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_item_d.status = found_q ? ST_FOUND : ST_NOT_FOUND;
          out_item_d.data   = '0;
          out_item_d.last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_cnt_q    <= '0;
      occ_q       <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_cnt_q    <= wr_cnt_d;
      occ_q       <= occ_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    out_item_q <= out_item_d;
  end

endmodule
